// File: hw/rtl/iida_pkg.sv
// shared types and constants for the indexed insert/delete array
package iida_pkg;

    // array geometry
    localparam int CAPACITY = 128;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // payload field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int FILL_W   = 8;

    // width that holds both a position and a count for compares
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // command queue between front and back
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_LVL_W  = $clog2(Q_DEPTH + 1);

    // request kinds
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // classified command handed from front to back
    typedef struct packed {
        logic                     do_ins;
        logic                     do_del;
        logic                     do_rd;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
        status_t                  status;
        logic [CNT_W-1:0]         count;
    } cmd_t;

endpackage

// File: hw/rtl/iida_front.sv
// front end: accepts requests, checks them against the tracked fill count
module iida_front
    import iida_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic                     q_full,
    output logic                     q_push,
    output cmd_t                     q_cmd
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic             is_full;
    logic             is_empty;

    assign s_ready  = !q_full;
    assign q_push   = s_valid && s_ready;
    assign pos_c    = CMP_W'(s_position);
    assign cnt_c    = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // classify the request and work out the count it leaves
    always_comb begin
        q_cmd        = '0;
        q_cmd.idx    = IDX_W'(s_position);
        q_cmd.value  = s_value;
        q_cmd.status = ST_OK;
        count_next   = count_reg;
        case (s_op)
            OP_INSERT: begin
                if (is_full) begin
                    q_cmd.status = ST_FULL;
                end else if (pos_c > cnt_c) begin
                    q_cmd.status = ST_RANGE;
                end else begin
                    q_cmd.do_ins = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (is_empty) begin
                    q_cmd.status = ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    q_cmd.status = ST_RANGE;
                end else begin
                    q_cmd.do_del = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (is_empty) begin
                    q_cmd.status = ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    q_cmd.status = ST_RANGE;
                end else begin
                    q_cmd.do_rd = 1'b1;
                end
            end
            default: begin
                q_cmd.status = ST_OK;
            end
        endcase
        q_cmd.count = count_next;
    end

    // tracked fill count, ahead of the back end by the queued commands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (q_push) begin
            count_reg <= count_next;
        end
    end

    // the tracked count stays within capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // an accepted insert that succeeds raises the count by one
    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && q_cmd.do_ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not raise the count");

endmodule

// File: hw/rtl/iida_queue.sv
// small command queue between the front and back ends
module iida_queue
    import iida_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t head_cmd
);

    cmd_t               slots [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_LVL_W-1:0] level_reg;

    assign full     = (level_reg == Q_LVL_W'(Q_DEPTH));
    assign q_valid  = (level_reg != '0);
    assign head_cmd = slots[rd_ptr_reg];

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    // no write into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    // no read from an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !q_valid))
        else $error("pop from empty queue");

endmodule

// File: hw/rtl/iida_back.sv
// back end: row of cells that all shift together on a pop, plus the result register
module iida_back
    import iida_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    input  cmd_t                     head_cmd,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic signed [DATA_W-1:0] m_read_value,
    output logic [FILL_W-1:0]        m_fill_count
);

    logic signed [DATA_W-1:0] cell_reg [CAPACITY];
    logic                     out_valid_reg;
    status_t                  status_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic [CNT_W-1:0]         count_reg;

    assign pop          = q_valid && (!out_valid_reg || m_ready);
    assign m_valid      = out_valid_reg;
    assign m_status     = status_reg;
    assign m_read_value = read_value_reg;
    assign m_fill_count = FILL_W'(count_reg);

    // each cell takes its lower neighbor, upper neighbor, the new word or itself
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] upper;

        if (g == 0) begin : g_lo_edge
            assign lower = '0;
        end else begin : g_lo
            assign lower = cell_reg[g-1];
        end

        if (g == CAPACITY - 1) begin : g_hi_edge
            assign upper = '0;
        end else begin : g_hi
            assign upper = cell_reg[g+1];
        end

        always_ff @(posedge aclk) begin
            if (pop && head_cmd.do_ins) begin
                if (IDX_W'(g) == head_cmd.idx) begin
                    cell_reg[g] <= head_cmd.value;
                end else if (IDX_W'(g) > head_cmd.idx) begin
                    cell_reg[g] <= lower;
                end
            end else if (pop && head_cmd.do_del) begin
                if (IDX_W'(g) >= head_cmd.idx) begin
                    cell_reg[g] <= upper;
                end
            end
        end
    end

    // result register, reloaded from the queue head whenever one waits and it is free or being taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg     <= head_cmd.status;
            read_value_reg <= head_cmd.do_rd ? cell_reg[head_cmd.idx] : '0;
            count_reg      <= head_cmd.count;
        end
    end

    // a popped command always shows up as a result next cycle
    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> out_valid_reg)
        else $error("popped command produced no result");

    // a failed request never returns data
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && status_reg != ST_OK |-> read_value_reg == '0)
        else $error("failed request returned data");

    // a waiting result is not overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> $stable(count_reg) && $stable(status_reg))
        else $error("waiting result overwritten");

endmodule

// File: hw/rtl/indexed_insert_delete_array_top.sv
// Ordered word array with insert, delete and read at an index.
// A request is held in the command queue; its result is registered when the back end pops it.
// Throughput: one request per cycle while the queue is not full; the whole cell row shifts at once.
// A two-entry command queue lets the front and the back stall independently.
// Reset (aresetn low, synchronous) empties the array and the queue; cells are not cleared.
module indexed_insert_delete_array_top
    import iida_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic signed [DATA_W-1:0] m_read_value,
    output logic [FILL_W-1:0]        m_fill_count
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // request checking
    iida_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_position (s_position),
        .s_value    (s_value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    // command queue
    iida_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .head_cmd (head_cmd)
    );

    // array update and result
    iida_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .head_cmd     (head_cmd),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_read_value (m_read_value),
        .m_fill_count (m_fill_count)
    );

endmodule
